>>> sv/rename_free_and_busy_list_assert.svh
// ----------------------------------------------------------------------------
// Rename free/busy list assertion macros
// Shared assertion forms for the rename bookkeeping checker.
// ----------------------------------------------------------------------------
`ifndef RENAME_FREE_AND_BUSY_LIST_ASSERT_SVH
`define RENAME_FREE_AND_BUSY_LIST_ASSERT_SVH

// same-cycle implication
`define RFBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RFBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rfbl_pkg.sv
// ----------------------------------------------------------------------------
// rfbl_pkg
// Types, codes and sizes shared by the rename free/busy list modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rfbl_pkg;
  localparam int NUM_PHYS    = 64;
  localparam int NUM_LOGICAL = 32;
  localparam int SLOTS       = NUM_PHYS - 1;
  localparam int PHYS_W      = 6;
  localparam int LOG_W       = 5;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int ENTRY_W     = PHYS_W + LOG_W + ADDR_W;

  localparam logic [1:0] FUNC_ASSIGN = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_FREE   = 2'd2;

  localparam logic [1:0] OP_OTHER  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_BRANCH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  typedef struct packed {
    logic capture;
    logic fifo_rd;
    logic assign_wr;
    logic idx_init_last;
    logic idx_init_zero;
    logic idx_dec;
    logic idx_inc;
    logic busy_rd;
    logic shift_rd;
    logic shift_wr;
    logic save_phys;
    logic push;
    logic set_found;
    logic set_empty;
    logic set_none;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       dest_zero;
    logic       query_zero;
    logic       free_empty;
    logic       busy_empty;
    logic       lk_match;
    logic       fr_match;
    logic       idx_zero;
    logic       idx_last;
    logic       idx_last2;
    logic       out_busy;
  } sts_t;
endpackage

>>> sv/rename_free_and_busy_list.sv
// ----------------------------------------------------------------------------
// rename_free_and_busy_list
// Register rename free FIFO and age-ordered busy list with lookup and free.
// ----------------------------------------------------------------------------
// Flow: assign takes the free FIFO head and writes a busy entry; lookup scans
//   newest first; free scans oldest first, compacts later entries, then pushes.
// Throughput: one item at a time; scan and compaction share the one busy RAM.
// Reset: free list holds 1 to 63 in order, busy list empty; no clearing pass.
`timescale 1ns / 1ps
module rename_free_and_busy_list import rfbl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [1:0]        op_class,
  input  logic [LOG_W-1:0]  reg_t,
  input  logic [LOG_W-1:0]  reg_d,
  input  logic [ADDR_W-1:0] instr_addr,
  input  logic [LOG_W-1:0]  query_reg,
  input  logic [ADDR_W-1:0] bound_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PHYS_W-1:0] phys_out,
  output logic              writer_found,
  output logic [ADDR_W-1:0] writer_addr,
  output logic [1:0]        status
);
  cmd_t cmd;
  sts_t sts;

  rfbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfbl_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .op_class     (op_class),
    .reg_t        (reg_t),
    .reg_d        (reg_d),
    .instr_addr   (instr_addr),
    .query_reg    (query_reg),
    .bound_addr   (bound_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .phys_out     (phys_out),
    .writer_found (writer_found),
    .writer_addr  (writer_addr),
    .status       (status)
  );
endmodule

>>> sv/rfbl_ram.sv
// ----------------------------------------------------------------------------
// rfbl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rfbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/rfbl_ctrl.sv
// ----------------------------------------------------------------------------
// rfbl_ctrl
// Sequencer for assign, lookup, free, busy-list compaction and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rfbl_ctrl import rfbl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DISP   = 11'b00000000010,
    S_ASN_WR = 11'b00000000100,
    S_LK_RD  = 11'b00000001000,
    S_LK_CMP = 11'b00000010000,
    S_FR_RD  = 11'b00000100000,
    S_FR_CMP = 11'b00001000000,
    S_SH_RD  = 11'b00010000000,
    S_SH_WR  = 11'b00100000000,
    S_PUSH   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.func)
          FUNC_ASSIGN: begin
            if (sts.dest_zero) begin
              state_next = S_DONE;
            end else if (sts.free_empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.fifo_rd = 1'b1;
              state_next  = S_ASN_WR;
            end
          end
          FUNC_LOOKUP: begin
            if (sts.busy_empty) begin
              state_next = S_DONE;
            end else begin
              cmd.idx_init_last = 1'b1;
              state_next        = S_LK_RD;
            end
          end
          FUNC_FREE: begin
            if (sts.busy_empty || sts.query_zero) begin
              cmd.set_none = 1'b1;
              state_next   = S_DONE;
            end else begin
              cmd.idx_init_zero = 1'b1;
              state_next        = S_FR_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ASN_WR: begin
        cmd.assign_wr = 1'b1;
        state_next    = S_DONE;
      end
      S_LK_RD: begin
        cmd.busy_rd = 1'b1;
        state_next  = S_LK_CMP;
      end
      S_LK_CMP: begin
        if (sts.lk_match) begin
          cmd.set_found = 1'b1;
          state_next    = S_DONE;
        end else if (sts.idx_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_LK_RD;
        end
      end
      S_FR_RD: begin
        cmd.busy_rd = 1'b1;
        state_next  = S_FR_CMP;
      end
      S_FR_CMP: begin
        if (sts.fr_match) begin
          cmd.save_phys = 1'b1;
          state_next    = sts.idx_last ? S_PUSH : S_SH_RD;
        end else if (sts.idx_last) begin
          cmd.set_none = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FR_RD;
        end
      end
      S_SH_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = sts.idx_last2 ? S_PUSH : S_SH_RD;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> sv/rfbl_dpath.sv
// ----------------------------------------------------------------------------
// rfbl_dpath
// Free FIFO, busy list storage, scan index, result and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rfbl_dpath import rfbl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        func,
  input  logic [1:0]        op_class,
  input  logic [LOG_W-1:0]  reg_t,
  input  logic [LOG_W-1:0]  reg_d,
  input  logic [ADDR_W-1:0] instr_addr,
  input  logic [LOG_W-1:0]  query_reg,
  input  logic [ADDR_W-1:0] bound_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PHYS_W-1:0] phys_out,
  output logic              writer_found,
  output logic [ADDR_W-1:0] writer_addr,
  output logic [1:0]        status
);
  logic [1:0]        func_q;
  logic [LOG_W-1:0]  dest_q, query_q;
  logic [ADDR_W-1:0] iaddr_q, bound_q;
  logic [IDX_W-1:0]  free_head;
  logic [CNT_W-1:0]  free_count, wr_fill;
  logic [IDX_W-1:0]  idx;
  logic [PHYS_W-1:0] phys_q;
  logic [PHYS_W-1:0] res_phys;
  logic              res_found;
  logic [ADDR_W-1:0] res_addr;
  logic [1:0]        res_status;

  logic [CNT_W-1:0]   busy_n;
  logic [CNT_W-1:0]   idx_ext;
  logic [LOG_W-1:0]   dest;
  logic [PHYS_W-1:0]  fifo_rdata, fifo_phys;
  logic [CNT_W:0]     tail_sum;
  logic [IDX_W-1:0]   tail;
  logic               busy_we;
  logic [IDX_W-1:0]   busy_waddr, busy_raddr;
  logic [ENTRY_W-1:0] busy_wdata, busy_rdata;
  logic [PHYS_W-1:0]  rd_phys;
  logic [LOG_W-1:0]   rd_log;
  logic [ADDR_W-1:0]  rd_addr;

  always_comb begin
    priority if (op_class == OP_LOAD) begin
      dest = reg_t;
    end else if (op_class == OP_STORE || op_class == OP_BRANCH) begin
      dest = '0;
    end else begin
      dest = reg_d;
    end
  end

  assign busy_n   = CNT_W'(SLOTS) - free_count;
  assign idx_ext  = {1'b0, idx};
  assign tail_sum = {2'b00, free_head} + {1'b0, free_count};
  assign tail     = (tail_sum >= (CNT_W + 1)'(SLOTS)) ?
                    IDX_W'(tail_sum - (CNT_W + 1)'(SLOTS)) : IDX_W'(tail_sum);
  assign fifo_phys = ({1'b0, free_head} < wr_fill) ? fifo_rdata :
                     PHYS_W'(free_head + 1'b1);
  assign {rd_phys, rd_log, rd_addr} = busy_rdata;

  assign busy_we    = cmd.assign_wr | cmd.shift_wr;
  assign busy_waddr = cmd.assign_wr ? IDX_W'(busy_n) : idx;
  assign busy_wdata = cmd.assign_wr ? {fifo_phys, dest_q, iaddr_q} : busy_rdata;
  assign busy_raddr = cmd.shift_rd ? IDX_W'(idx + 1'b1) : idx;

  rfbl_ram #(.WIDTH(PHYS_W), .DEPTH(NUM_PHYS)) u_free_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail),
    .wdata (phys_q),
    .raddr (free_head),
    .rdata (fifo_rdata)
  );

  rfbl_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_PHYS)) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .raddr (busy_raddr),
    .rdata (busy_rdata)
  );

  always_comb begin
    sts            = '0;
    sts.func       = func_q;
    sts.dest_zero  = (dest_q == '0);
    sts.query_zero = (query_q == '0);
    sts.free_empty = (free_count == '0);
    sts.busy_empty = (busy_n == '0);
    sts.fr_match   = (rd_log == query_q);
    sts.lk_match   = (rd_log == query_q) && (rd_addr < bound_q);
    sts.idx_zero   = (idx == '0);
    sts.idx_last   = (idx_ext + 1'b1 == busy_n);
    sts.idx_last2  = (idx_ext + 2'd2 == busy_n);
    sts.out_busy   = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      free_count <= CNT_W'(SLOTS);
      wr_fill    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.assign_wr) begin
        free_head  <= (free_head == IDX_W'(SLOTS - 1)) ? '0 : free_head + 1'b1;
        free_count <= free_count - 1'b1;
      end
      if (cmd.push) begin
        free_count <= free_count + 1'b1;
        if (wr_fill != CNT_W'(SLOTS)) begin
          wr_fill <= wr_fill + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= func;
      dest_q     <= dest;
      query_q    <= query_reg;
      iaddr_q    <= instr_addr;
      bound_q    <= bound_addr;
      res_phys   <= '0;
      res_found  <= 1'b0;
      res_addr   <= '0;
      res_status <= ST_OK;
    end
    if (cmd.idx_init_last) begin
      idx <= IDX_W'(busy_n - 1'b1);
    end else if (cmd.idx_init_zero) begin
      idx <= '0;
    end else if (cmd.idx_dec) begin
      idx <= idx - 1'b1;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.save_phys) begin
      phys_q <= rd_phys;
    end
    if (cmd.assign_wr) begin
      res_phys <= fifo_phys;
    end
    if (cmd.set_found) begin
      res_found <= 1'b1;
      res_addr  <= rd_addr;
    end
    if (cmd.set_empty) begin
      res_status <= ST_EMPTY;
    end
    if (cmd.set_none) begin
      res_status <= ST_NONE;
    end
    if (cmd.emit) begin
      phys_out     <= res_phys;
      writer_found <= res_found;
      writer_addr  <= res_addr;
      status       <= res_status;
    end
  end
endmodule

>>> sv/rfbl_checker.sv
// ----------------------------------------------------------------------------
// rfbl_checker
// Port-level checks for the rename free/busy list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rename_free_and_busy_list_assert.svh"
module rfbl_checker import rfbl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PHYS_W-1:0] phys_out,
  input logic              writer_found,
  input logic [ADDR_W-1:0] writer_addr,
  input logic [1:0]        status
);
  `RFBL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `RFBL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transfer taken")
  `RFBL_ASSERT_NOW(a_empty_no_phys, out_valid && status == ST_EMPTY, phys_out == '0, "phys on empty")
  `RFBL_ASSERT_NOW(a_found_clean, out_valid && writer_found, status == ST_OK && phys_out == '0, "bad lookup result")
  `RFBL_ASSERT_NOW(a_addr_found, out_valid && !writer_found, writer_addr == '0, "stray writer address")
endmodule

bind rename_free_and_busy_list rfbl_checker u_rfbl_checker (.*);

>>> verif/rename_free_and_busy_list_test.sv
// ----------------------------------------------------------------------------
// Rename free/busy list testbench
// Drives assign, lookup and free requests through the valid/ready input and
// compares every response against a behavioral model of the free FIFO and
// the age-ordered busy list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rename_free_and_busy_list_test;
  import rfbl_pkg::*;

  typedef struct packed {
    logic [1:0]        func;
    logic [1:0]        op_class;
    logic [LOG_W-1:0]  reg_t;
    logic [LOG_W-1:0]  reg_d;
    logic [ADDR_W-1:0] instr_addr;
    logic [LOG_W-1:0]  query_reg;
    logic [ADDR_W-1:0] bound_addr;
  } req_t;

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic              found;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        status;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [1:0] op_class = '0;
  logic [LOG_W-1:0] reg_t = '0;
  logic [LOG_W-1:0] reg_d = '0;
  logic [ADDR_W-1:0] instr_addr = '0;
  logic [LOG_W-1:0] query_reg = '0;
  logic [ADDR_W-1:0] bound_addr = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PHYS_W-1:0] phys_out;
  logic writer_found;
  logic [ADDR_W-1:0] writer_addr;
  logic [1:0] status;

  rename_free_and_busy_list dut (.*);

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int cycle = 0;
  int hold_cycles = 0;
  bit quiet = 0;
  bit stim_done = 0;

  logic [PHYS_W-1:0] free_q[$];
  logic [PHYS_W-1:0] bsy_p[$];
  logic [LOG_W-1:0]  bsy_l[$];
  logic [ADDR_W-1:0] bsy_a[$];

  function automatic rsp_t rename_predict(req_t r);
    rsp_t o;
    logic [LOG_W-1:0] dst;
    int hit;
    o = '0;
    case (r.func)
      FUNC_ASSIGN: begin
        if (r.op_class == OP_LOAD) dst = r.reg_t;
        else if (r.op_class == OP_STORE || r.op_class == OP_BRANCH) dst = '0;
        else dst = r.reg_d;
        if (dst != 0) begin
          if (free_q.size() == 0) o.status = ST_EMPTY;
          else begin
            o.phys = free_q.pop_front();
            bsy_p.push_back(o.phys);
            bsy_l.push_back(dst);
            bsy_a.push_back(r.instr_addr);
          end
        end
      end
      FUNC_LOOKUP: begin
        foreach (bsy_l[i])
          if (bsy_l[i] == r.query_reg && bsy_a[i] < r.bound_addr) begin
            o.found = 1'b1;
            o.waddr = bsy_a[i];
          end
      end
      FUNC_FREE: begin
        hit = -1;
        if (r.query_reg != 0)
          foreach (bsy_l[i])
            if (hit < 0 && bsy_l[i] == r.query_reg) hit = i;
        if (hit < 0) o.status = ST_NONE;
        else begin
          free_q.push_back(bsy_p[hit]);
          bsy_p.delete(hit);
          bsy_l.delete(hit);
          bsy_a.delete(hit);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic req_t rand_req();
    req_t r;
    int k;
    r.op_class = $urandom_range(0, 3);
    r.reg_t = $urandom;
    r.reg_d = $urandom;
    r.query_reg = $urandom_range(0, 7);
    r.instr_addr = $urandom;
    r.bound_addr = $urandom;
    k = $urandom_range(0, 99);
    if (k < 45) r.func = FUNC_ASSIGN;
    else if (k < 70) r.func = FUNC_LOOKUP;
    else if (k < 97) r.func = FUNC_FREE;
    else r.func = 2'd3;
    if ($urandom_range(0, 3) != 0) begin
      r.reg_t = $urandom_range(0, 7);
      r.reg_d = $urandom_range(0, 7);
    end
    if ($urandom_range(0, 9) == 0) r.query_reg = $urandom;
    if ($urandom_range(0, 9) == 0) r.bound_addr = '1;
    return r;
  endfunction

  function automatic req_t mk(logic [1:0] f, logic [1:0] oc, logic [4:0] t, logic [4:0] d,
                              logic [31:0] a, logic [4:0] q, logic [31:0] b);
    req_t r;
    r = '{f, oc, t, d, a, q, b};
    return r;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 1; i <= SLOTS; i++) free_q.push_back(PHYS_W'(i));
    pending_reqs.push_back(mk(FUNC_ASSIGN, OP_OTHER, 5'd0, 5'd31, 32'hffffffff, 5'd0, 32'd0));
    pending_reqs.push_back(mk(FUNC_ASSIGN, OP_LOAD, 5'd31, 5'd0, 32'd0, 5'd31, 32'd0));
    pending_reqs.push_back(mk(FUNC_ASSIGN, OP_STORE, 5'd5, 5'd6, 32'd10, 5'd0, 32'd0));
    pending_reqs.push_back(mk(FUNC_ASSIGN, OP_BRANCH, 5'd5, 5'd6, 32'd10, 5'd0, 32'd0));
    pending_reqs.push_back(mk(FUNC_ASSIGN, OP_OTHER, 5'd3, 5'd0, 32'd10, 5'd0, 32'd0));
    pending_reqs.push_back(mk(FUNC_LOOKUP, OP_OTHER, 5'd0, 5'd0, 32'd0, 5'd31, 32'hffffffff));
    pending_reqs.push_back(mk(FUNC_LOOKUP, OP_OTHER, 5'd0, 5'd0, 32'd0, 5'd31, 32'd0));
    pending_reqs.push_back(mk(FUNC_LOOKUP, OP_OTHER, 5'd0, 5'd0, 32'd0, 5'd0, 32'hffffffff));
    pending_reqs.push_back(mk(FUNC_FREE, OP_OTHER, 5'd0, 5'd0, 32'd0, 5'd0, 32'd0));
    pending_reqs.push_back(mk(FUNC_FREE, OP_OTHER, 5'd0, 5'd0, 32'd0, 5'd7, 32'd0));
    pending_reqs.push_back(mk(2'd3, 2'd3, 5'd31, 5'd31, 32'hffffffff, 5'd31, 32'hffffffff));
    pending_reqs.push_back(mk(FUNC_FREE, OP_OTHER, 5'd0, 5'd0, 32'd0, 5'd31, 32'd0));
    for (int i = 0; i < 66; i++)
      pending_reqs.push_back(mk(FUNC_ASSIGN, OP_OTHER, 5'd0, 5'(1 + i % 31), $urandom,
                                5'd0, 32'd0));
    for (int i = 0; i < 70; i++)
      pending_reqs.push_back(mk(FUNC_FREE, OP_OTHER, 5'd0, 5'd0, 32'd0, 5'(1 + i % 31), 32'd0));
    for (int i = 0; i < 800; i++) pending_reqs.push_back(rand_req());
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    quiet <= (cycle > 2000 && cycle < 3500);
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(rename_predict(pending_reqs.pop_front()));
      end
      if ((!in_valid || in_ready) && pending_reqs.size() > 0) begin
        if (quiet || $urandom_range(0, 99) >= 27) begin
          req_t n;
          n = pending_reqs[0];
          in_valid <= 1'b1;
          {func, op_class, reg_t, reg_d, instr_addr, query_reg, bound_addr} <= n;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
      if (!stim_done && pending_reqs.size() == 0) stim_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 0, 0);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (phys_out !== e.phys) report_mismatch("phys_out", phys_out, e.phys);
          if (writer_found !== e.found) report_mismatch("writer_found", writer_found, e.found);
          if (writer_addr !== e.waddr) report_mismatch("writer_addr", writer_addr, e.waddr);
          if (status !== e.status) report_mismatch("status", status, e.status);
        end
      end
      if (cycle == 5000) hold_cycles <= 400;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      out_ready <= (hold_cycles == 0 && cycle != 5000) &&
                   (quiet || $urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    wait (stim_done);
    while (expected_rsps.size() > 0 || in_valid) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
